@@ hdl/tsag_pkg.sv @@
// package for the tensor split address generator
// constants, register index codes and widths; no dependencies
package tsag_pkg;

   localparam int VEC = 4;                       // elements per vector item, power of two
   localparam int VEC_SHIFT = (VEC > 1) ? $clog2(VEC) : 0;
   localparam int CNT_W = (VEC > 1) ? $clog2(VEC) : 1;
   localparam int OFFSET_BITS = 24;
   localparam int DATA_W = 24;
   localparam int PART_W = 6;
   localparam int PARTQ_STAGES = PART_W;         // quotient bits of the part division
   localparam int ROWQ_STAGES = DATA_W;          // quotient bits of the row division
   localparam int MAX_PARTS = 64;

   typedef enum logic [2:0] {
      REG_INPUT_ROW_LENGTH   = 3'd0,
      REG_PART_ROW_LENGTH    = 3'd1,
      REG_PART_ELEMENT_COUNT = 3'd2,
      REG_FIRST_PART_INDEX   = 3'd3,
      REG_PART_COUNT         = 3'd4
   } csr_index_type;

endpackage

@@ hdl/tensor_split_address_generator.sv @@
// tensor split address generator: work item number in, copy addresses out
// depends on tsag_pkg
//
//  channel | ports                          | direction | moves
//  --------+--------------------------------+-----------+------------------------------
//  req     | req_valid/ready, item_number   | in        | one work item number
//  rsp     | rsp_valid/ready, 5 fields      | out       | one address per element
//  csr     | csr_write_enable/index/data    | in        | register write, no read-back
//
// a vector item gives VEC results, a tail item one result, an item past the end none;
// the output register loads the next item once a vector item's last element is taken.
// from accept to first result an item passes one classify stage, six part-division
// stages, one offset stage, 24 row-division stages, multiply, add and output register.
// one global advance moves all stages before it; a stall at rsp or a stepping vector
// item holds them all, empty slots too, once the address stage holds an item. reset is
// synchronous, clears valid bits and counter, loads config defaults; no clearing pass.
module tensor_split_address_generator (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [tsag_pkg::DATA_W-1:0]      req_item_number,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [tsag_pkg::PART_W-1:0]      rsp_part_number,
   output logic [tsag_pkg::DATA_W-1:0]      rsp_part_offset,
   output logic [tsag_pkg::OFFSET_BITS-1:0] rsp_source_offset,
   output logic                             rsp_burst_ok,
   output logic                             rsp_last_of_item,
   input  logic                             csr_write_enable,
   input  logic [2:0]                       csr_index,
   input  logic [tsag_pkg::DATA_W-1:0]      csr_write_data
);

   localparam int DW = tsag_pkg::DATA_W;
   localparam int PW = tsag_pkg::PART_W;
   localparam int OW = tsag_pkg::OFFSET_BITS;
   localparam int PVW = DW - tsag_pkg::VEC_SHIFT;
   localparam int NPQ = tsag_pkg::PARTQ_STAGES;
   localparam int NRQ = tsag_pkg::ROWQ_STAGES;
   localparam int VNW = PVW + 7;

   // configuration registers
   logic [DW-1:0] irl_ff, prl_ff, pec_ff;
   logic [15:0]   fpi_ff;
   logic [6:0]    pc_ff;
   logic [6:0]    pc_eff;
   logic [VNW-1:0] vn;
   logic [VNW:0]   tot;

   logic [DW-1:0]  prl_eff;
   logic [PVW-1:0] pv;
   logic [tsag_pkg::VEC_SHIFT:0] pt;

   assign prl_eff = (prl_ff == '0) ? DW'(1) : prl_ff;
   assign pv = pec_ff[DW-1:tsag_pkg::VEC_SHIFT];
   assign pt = (tsag_pkg::VEC_SHIFT + 1)'(pec_ff & DW'(tsag_pkg::VEC - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         irl_ff <= DW'(1);
         prl_ff <= DW'(1);
         pec_ff <= '0;
         fpi_ff <= '0;
         pc_ff  <= 7'd1;
      end else if (csr_write_enable) begin
         case (csr_index)
            tsag_pkg::REG_INPUT_ROW_LENGTH:   irl_ff <= csr_write_data;
            tsag_pkg::REG_PART_ROW_LENGTH:    prl_ff <= csr_write_data;
            tsag_pkg::REG_PART_ELEMENT_COUNT: pec_ff <= csr_write_data;
            tsag_pkg::REG_FIRST_PART_INDEX:   fpi_ff <= csr_write_data[15:0];
            tsag_pkg::REG_PART_COUNT:         pc_ff  <= csr_write_data[6:0];
            default: ;
         endcase
      end
   end

   // derived counts, valid in the cycle right after a write
   assign pc_eff = (pc_ff > 7'(tsag_pkg::MAX_PARTS)) ? 7'(tsag_pkg::MAX_PARTS) : pc_ff;
   assign vn     = VNW'(pv) * VNW'(pc_eff);
   assign tot    = (VNW + 1)'(vn) + (VNW + 1)'(pt) * (VNW + 1)'(pc_eff);

   logic advance;
   logic emit_load;
   logic d_v_ff;

   assign advance = !d_v_ff || emit_load;
   assign req_ready = advance;

   // part division stages: part = n / d, rem = n % d
   logic          a_v_ff   [0:NPQ];
   logic          a_vec_ff [0:NPQ];
   logic [DW-1:0]  a_r_ff  [0:NPQ];
   logic [PVW-1:0] a_d_ff  [0:NPQ];
   logic [PW-1:0]  a_q_ff  [0:NPQ];

   logic          id_vec, id_live;
   assign id_vec  = (VNW + 1)'(req_item_number) < (VNW + 1)'(vn);
   assign id_live = (VNW + 1)'(req_item_number) < tot;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff[0] <= 1'b0;
      end else if (advance) begin
         a_v_ff[0] <= req_valid && id_live;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_vec_ff[0] <= id_vec;
         a_r_ff[0]   <= id_vec ? req_item_number : req_item_number - vn[DW-1:0];
         a_d_ff[0]   <= id_vec ? pv : PVW'(pt);
         a_q_ff[0]   <= '0;
      end
   end

   for (genvar j = 0; j < NPQ; j++) begin : g_part_div
      localparam int K = NPQ - 1 - j;
      logic [DW+NPQ-1:0] sh;
      logic              ge;
      assign sh = (DW + NPQ)'(a_d_ff[j]) << K;
      assign ge = (DW + NPQ)'(a_r_ff[j]) >= sh;
      always_ff @(posedge clock) begin
         if (reset) begin
            a_v_ff[j+1] <= 1'b0;
         end else if (advance) begin
            a_v_ff[j+1] <= a_v_ff[j];
         end
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            a_vec_ff[j+1] <= a_vec_ff[j];
            a_d_ff[j+1]   <= a_d_ff[j];
            a_r_ff[j+1]   <= ge ? a_r_ff[j] - sh[DW-1:0] : a_r_ff[j];
            a_q_ff[j+1]   <= a_q_ff[j] | (ge ? PW'(1) << K : '0);
         end
      end
   end

   // row division stages: row = poff / prl, col = poff % prl
   logic          b_v_ff    [0:NRQ];
   logic          b_vec_ff  [0:NRQ];
   logic [PW-1:0] b_part_ff [0:NRQ];
   logic [DW-1:0] b_poff_ff [0:NRQ];
   logic [DW-1:0] b_r_ff    [0:NRQ];
   logic [DW-1:0] b_q_ff    [0:NRQ];

   logic [DW-1:0] poff_in;
   assign poff_in = a_vec_ff[NPQ] ? a_r_ff[NPQ] << tsag_pkg::VEC_SHIFT
                                  : pec_ff - DW'(pt) + a_r_ff[NPQ];

   always_ff @(posedge clock) begin
      if (reset) begin
         b_v_ff[0] <= 1'b0;
      end else if (advance) begin
         b_v_ff[0] <= a_v_ff[NPQ];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b_vec_ff[0]  <= a_vec_ff[NPQ];
         b_part_ff[0] <= a_q_ff[NPQ];
         b_poff_ff[0] <= poff_in;
         b_r_ff[0]    <= poff_in;
         b_q_ff[0]    <= '0;
      end
   end

   for (genvar j = 0; j < NRQ; j++) begin : g_row_div
      localparam int K = NRQ - 1 - j;
      logic [2*DW-1:0] sh;
      logic            ge;
      assign sh = (2 * DW)'(prl_eff) << K;
      assign ge = (2 * DW)'(b_r_ff[j]) >= sh;
      always_ff @(posedge clock) begin
         if (reset) begin
            b_v_ff[j+1] <= 1'b0;
         end else if (advance) begin
            b_v_ff[j+1] <= b_v_ff[j];
         end
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            b_vec_ff[j+1]  <= b_vec_ff[j];
            b_part_ff[j+1] <= b_part_ff[j];
            b_poff_ff[j+1] <= b_poff_ff[j];
            b_r_ff[j+1]    <= ge ? b_r_ff[j] - sh[DW-1:0] : b_r_ff[j];
            b_q_ff[j+1]    <= b_q_ff[j] | (ge ? DW'(1) << K : '0);
         end
      end
   end

   // multiply stage
   logic          c_v_ff, c_vec_ff;
   logic [PW-1:0] c_part_ff;
   logic [DW-1:0] c_poff_ff, c_col_ff;
   logic [OW-1:0] c_m1_ff, c_m2_ff;
   logic [16:0]   split_index;
   logic [2*DW-1:0] m1_full;
   logic [DW+16:0]  m2_full;

   assign split_index = 17'(fpi_ff) + 17'(b_part_ff[NRQ]);
   assign m1_full = b_q_ff[NRQ] * irl_ff;
   assign m2_full = (DW + 17)'(split_index) * (DW + 17)'(prl_eff);

   always_ff @(posedge clock) begin
      if (reset) begin
         c_v_ff <= 1'b0;
      end else if (advance) begin
         c_v_ff <= b_v_ff[NRQ];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         c_vec_ff  <= b_vec_ff[NRQ];
         c_part_ff <= b_part_ff[NRQ];
         c_poff_ff <= b_poff_ff[NRQ];
         c_col_ff  <= b_r_ff[NRQ];
         c_m1_ff   <= m1_full[OW-1:0];
         c_m2_ff   <= m2_full[OW-1:0];
      end
   end

   // address stage
   logic          d_vec_ff, d_burst_ff;
   logic [PW-1:0] d_part_ff;
   logic [DW-1:0] d_poff_ff, d_col_ff;
   logic [OW-1:0] d_src_ff;
   logic [OW-1:0] src_in;
   logic          burst_in;

   assign src_in = c_m1_ff + c_m2_ff + OW'(c_col_ff);
   assign burst_in = c_vec_ff
                     && ((src_in & OW'(tsag_pkg::VEC - 1)) == '0)
                     && ((DW + 1)'(c_col_ff) + (DW + 1)'(tsag_pkg::VEC) <= (DW + 1)'(prl_eff));

   always_ff @(posedge clock) begin
      if (reset) begin
         d_v_ff <= 1'b0;
      end else if (advance) begin
         d_v_ff <= c_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         d_vec_ff   <= c_vec_ff;
         d_part_ff  <= c_part_ff;
         d_poff_ff  <= c_poff_ff;
         d_col_ff   <= c_col_ff;
         d_src_ff   <= src_in;
         d_burst_ff <= burst_in;
      end
   end

   // output register, steps through the elements of a vector item
   logic             rsp_valid_ff, burst_ff, last_ff;
   logic [PW-1:0]    part_ff;
   logic [DW-1:0]    poff_ff, col_ff;
   logic [OW-1:0]    src_ff;
   logic [tsag_pkg::CNT_W-1:0] cnt_ff;

   logic             rsp_valid_in, burst_in_o, last_in;
   logic [PW-1:0]    part_in;
   logic [DW-1:0]    poff_o_in, col_in;
   logic [OW-1:0]    src_o_in;
   logic [tsag_pkg::CNT_W-1:0] cnt_in;
   logic             free, wrap;

   assign free = !rsp_valid_ff || rsp_ready;
   assign emit_load = !rsp_valid_ff || (rsp_ready && cnt_ff == '0);
   assign wrap = (DW + 1)'(col_ff) + (DW + 1)'(1) >= (DW + 1)'(prl_eff);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      burst_in_o   = burst_ff;
      last_in      = last_ff;
      part_in      = part_ff;
      poff_o_in    = poff_ff;
      col_in       = col_ff;
      src_o_in     = src_ff;
      cnt_in       = cnt_ff;
      if (free) begin
         if (rsp_valid_ff && cnt_ff != '0) begin
            poff_o_in = poff_ff + DW'(1);
            cnt_in    = cnt_ff - 1'b1;
            last_in   = (cnt_ff == tsag_pkg::CNT_W'(1));
            if (wrap) begin
               src_o_in = src_ff - OW'(col_ff) + OW'(irl_ff);
               col_in   = '0;
            end else begin
               src_o_in = src_ff + OW'(1);
               col_in   = col_ff + DW'(1);
            end
         end else begin
            rsp_valid_in = d_v_ff;
            burst_in_o   = d_burst_ff;
            part_in      = d_part_ff;
            poff_o_in    = d_poff_ff;
            col_in       = d_col_ff;
            src_o_in     = d_src_ff;
            cnt_in       = d_vec_ff ? tsag_pkg::CNT_W'(tsag_pkg::VEC - 1) : '0;
            last_in      = !d_vec_ff || (tsag_pkg::VEC == 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      burst_ff <= burst_in_o;
      last_ff  <= last_in;
      part_ff  <= part_in;
      poff_ff  <= poff_o_in;
      col_ff   <= col_in;
      src_ff   <= src_o_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_part_number   = part_ff;
   assign rsp_part_offset   = poff_ff;
   assign rsp_source_offset = src_ff;
   assign rsp_burst_ok      = burst_ff;
   assign rsp_last_of_item  = last_ff;

endmodule

@@ tb/tsag_checker.sv @@
// checker for the tensor split address generator: watches req and rsp,
// predicts the addresses of each accepted item and compares; depends on tsag_pkg
module tsag_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  logic [tsag_pkg::DATA_W-1:0]      req_item_number,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic [tsag_pkg::PART_W-1:0]      rsp_part_number,
   input  logic [tsag_pkg::DATA_W-1:0]      rsp_part_offset,
   input  logic [tsag_pkg::OFFSET_BITS-1:0] rsp_source_offset,
   input  logic                             rsp_burst_ok,
   input  logic                             rsp_last_of_item,
   input  logic                             csr_write_enable,
   input  logic [2:0]                       csr_index,
   input  logic [tsag_pkg::DATA_W-1:0]      csr_write_data,
   output int                               error_count,
   output int                               pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [tsag_pkg::PART_W-1:0]      part;
      logic [tsag_pkg::DATA_W-1:0]      poff;
      logic [tsag_pkg::OFFSET_BITS-1:0] src;
      logic                             burst;
      logic                             last;
   } address_type;

   address_type addr_q[$];
   logic [23:0] in_row_len, part_row_len, part_elems;
   logic [15:0] first_part;
   logic [6:0]  num_parts;

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic logic [tsag_pkg::OFFSET_BITS-1:0] source_of(longint unsigned part,
         longint unsigned poff, longint unsigned prl);
      longint unsigned row, col;
      row = poff / prl;
      col = poff % prl;
      return tsag_pkg::OFFSET_BITS'(row * in_row_len + (first_part + part) * prl + col);
   endfunction

   task automatic expand_item(input logic [23:0] id);
      longint unsigned pc, prl, pv, pt, vn, tn, part, poff, col, src;
      address_type a;
      pc  = (num_parts > 64) ? 64 : num_parts;
      prl = (part_row_len == 0) ? 1 : part_row_len;
      pv  = part_elems / tsag_pkg::VEC;
      pt  = part_elems - pv * tsag_pkg::VEC;
      vn  = pv * pc;
      tn  = pt * pc;
      if (id >= vn + tn) return;
      if (id < vn) begin
         part = id / pv;
         poff = (id - part * pv) * tsag_pkg::VEC;
         col  = poff % prl;
         src  = source_of(part, poff, prl);
         a.burst = ((src % tsag_pkg::VEC) == 0) && (col + tsag_pkg::VEC <= prl);
         for (int i = 0; i < tsag_pkg::VEC; i++) begin
            a.part = tsag_pkg::PART_W'(part);
            a.poff = tsag_pkg::DATA_W'(poff + i);
            a.src  = tsag_pkg::OFFSET_BITS'(src);
            a.last = (i == tsag_pkg::VEC - 1);
            addr_q.push_back(a);
            // wrap to the next input row at the end of a part row
            if (col + 1 >= prl) begin
               src = (src - col + in_row_len) & ((64'd1 << tsag_pkg::OFFSET_BITS) - 1);
               col = 0;
            end else begin
               col++;
               src = (src + 1) & ((64'd1 << tsag_pkg::OFFSET_BITS) - 1);
            end
         end
      end else begin
         part = (id - vn) / pt;
         poff = part_elems - pt + (id - vn - part * pt);
         a.part  = tsag_pkg::PART_W'(part);
         a.poff  = tsag_pkg::DATA_W'(poff);
         a.src   = source_of(part, poff, prl);
         a.burst = 1'b0;
         a.last  = 1'b1;
         addr_q.push_back(a);
      end
   endtask

   initial begin
      error_count = 0;
      pending_count = 0;
   end

   always @(posedge clock) begin
      address_type want;
      if (reset) begin
         in_row_len <= 1; part_row_len <= 1; part_elems <= 0;
         first_part <= 0; num_parts <= 1;
      end else begin
         if (csr_write_enable) begin
            case (tsag_pkg::csr_index_type'(csr_index))
               tsag_pkg::REG_INPUT_ROW_LENGTH:   in_row_len   <= csr_write_data;
               tsag_pkg::REG_PART_ROW_LENGTH:    part_row_len <= csr_write_data;
               tsag_pkg::REG_PART_ELEMENT_COUNT: part_elems   <= csr_write_data;
               tsag_pkg::REG_FIRST_PART_INDEX:   first_part   <= csr_write_data[15:0];
               tsag_pkg::REG_PART_COUNT:         num_parts    <= csr_write_data[6:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) expand_item(req_item_number);
         if (rsp_valid && rsp_ready) begin
            if (addr_q.size() == 0) begin
               report("unexpected item", rsp_source_offset, 0);
            end else begin
               want = addr_q.pop_front();
               if (rsp_part_number !== want.part) report("part_number", rsp_part_number, want.part);
               if (rsp_part_offset !== want.poff) report("part_offset", rsp_part_offset, want.poff);
               if (rsp_source_offset !== want.src)
                  report("source_offset", rsp_source_offset, want.src);
               if (rsp_burst_ok !== want.burst) report("burst_ok", rsp_burst_ok, want.burst);
               if (rsp_last_of_item !== want.last)
                  report("last_of_item", rsp_last_of_item, want.last);
            end
         end
         pending_count = addr_q.size();
      end
   end
endmodule

@@ tb/tb.sv @@
// testbench top for the tensor split address generator: clock, reset, stimulus,
// configuration phases and verdict; depends on tsag_pkg and tsag_checker
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY = 40;
   localparam longint CYCLE_LIMIT = 400000;

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_ready, rsp_valid, rsp_ready = 0;
   logic [tsag_pkg::DATA_W-1:0] req_item_number = 0;
   logic [tsag_pkg::PART_W-1:0] rsp_part_number;
   logic [tsag_pkg::DATA_W-1:0] rsp_part_offset;
   logic [tsag_pkg::OFFSET_BITS-1:0] rsp_source_offset;
   logic rsp_burst_ok, rsp_last_of_item;
   logic csr_write_enable = 0;
   logic [2:0] csr_index = 0;
   logic [tsag_pkg::DATA_W-1:0] csr_write_data = 0;
   int error_count, pending_count;
   longint cycle_count = 0;
   bit no_idle = 0;
   int hold_cycles = 0;
   int total_items;   // item count of the current config, for well-formed numbers

   always #5 clock = ~clock;

   tensor_split_address_generator dut (.*);
   tsag_checker chk (.*);

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL tensor_split_address_generator");
         $finish;
      end
   end

   // receiver: random stalls, plus a long hold-off when requested
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ready <= 0;
      end else begin
         rsp_ready <= no_idle || ($urandom_range(99) >= 11);
      end
   end

   // enable stays high until the caller is done writing
   task automatic csr_write(input tsag_pkg::csr_index_type idx, input logic [23:0] data);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_write_data <= data;
      @(negedge clock);
   endtask

   // valid stays high after the accept until the next item or a drain
   task automatic send_item(input logic [23:0] id);
      while (!no_idle && $urandom_range(99) < 11) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_item_number <= id;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (pending_count != 0) @(negedge clock);
      repeat (LATENCY) @(negedge clock);
   endtask

   task automatic configure(input logic [23:0] irl, input logic [23:0] prl,
         input logic [23:0] pec, input logic [15:0] fpi, input logic [6:0] pc);
      int pcl;
      drain();
      csr_write(tsag_pkg::REG_INPUT_ROW_LENGTH, irl);
      csr_write(tsag_pkg::REG_PART_ROW_LENGTH, prl);
      csr_write(tsag_pkg::REG_PART_ELEMENT_COUNT, pec);
      csr_write(tsag_pkg::REG_FIRST_PART_INDEX, 24'(fpi));
      csr_write(tsag_pkg::REG_PART_COUNT, 24'(pc));
      csr_write_enable <= 0;
      pcl = (pc > 64) ? 64 : pc;
      total_items = (pec / tsag_pkg::VEC) * pcl + (pec % tsag_pkg::VEC) * pcl;
   endtask

   task automatic random_phase(input int n);
      logic [23:0] id;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(9) < 8 && total_items > 0) id = 24'($urandom_range(total_items - 1));
         else if ($urandom_range(1)) id = 24'($urandom);
         else id = 24'(total_items + $urandom_range(3));
         send_item(id);
      end
   endtask

   initial begin
      repeat (9) @(negedge clock);
      reset <= 0;
      @(negedge clock);
      // reset config: zero elements, nothing comes out
      send_item(0);
      send_item(24'hFFFFFF);
      // small split with tails and row wrap
      configure(10, 3, 7, 2, 3);
      for (int i = 0; i < 12; i++) send_item(24'(i));
      // extremes: part count above 64, zero part row length
      configure(24'hFFFFFF, 0, 24'hFFFFFF, 16'hFFFF, 7'h7F);
      send_item(0);
      send_item(24'hFFFFFF);
      send_item(24'hFFFFFE);
      send_item(24'(24'h3FFFFF * 64 - 1));
      configure(24'h800001, 24'hFFFFFF, 9, 16'h5555, 0);
      send_item(0);
      send_item(3);
      configure(16, 8, 13, 1, 64);
      send_item(0); send_item(191); send_item(192); send_item(255); send_item(256);
      random_phase(25);
      // back-pressure: receiver holds off while sender keeps offering live items
      hold_cycles = 300;
      for (int i = 0; i < 60; i++) send_item(24'($urandom_range(total_items - 1)));
      configure(24'($urandom), 24'($urandom_range(1, 12)), 24'($urandom_range(0, 40)),
                16'($urandom), 7'($urandom_range(0, 70)));
      no_idle = 1;
      random_phase(30);
      no_idle = 0;
      configure(24'($urandom), 24'($urandom), 24'($urandom), 16'($urandom), 7'($urandom));
      random_phase(25);
      configure(1, 1, 24'hFFFFFF, 0, 1);
      random_phase(25);
      configure(24'($urandom_range(1, 50)), 24'($urandom_range(1, 9)),
                24'($urandom_range(4, 30)), 16'($urandom_range(0, 5)),
                7'($urandom_range(1, 8)));
      random_phase(20);
      drain();
      if (error_count == 0 && pending_count == 0) begin
         $display("PASS tensor_split_address_generator");
      end else begin
         $display("FAIL tensor_split_address_generator");
      end
      $finish;
   end
endmodule
